// ----- design/bpa_pkg.sv -----
// Shared widths, operation codes and types for the buffer pool allocator.
package bpa_pkg;

	localparam int SLOT_W  = 4;
	localparam int FREE_W  = 5;
	localparam int TOTAL_W = 32;
	localparam int LEVEL_W = 16;
	localparam int TIME_W  = 32;
	// Widest slot index and busy count over the supported pool sizes (up to 64 slots).
	localparam int IDX_MAX_W = 6;
	localparam int CNT_MAX_W = 7;

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [LEVEL_W-1:0] LIMIT_RESET = 16'd10;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'hFFFF;

	typedef struct packed {
		logic                 found;
		logic [IDX_MAX_W-1:0] idx;
	} free_slot_t;

endpackage

// ----- design/bpa_free_enc.sv -----
// Priority encoder that finds the lowest free slot in the busy bitmap.
module bpa_free_enc #(
	parameter int SLOT_COUNT = 16
) (
	input  logic [SLOT_COUNT-1:0] busy_map,
	output bpa_pkg::free_slot_t   free_slot
);
	import bpa_pkg::*;

	// Scan from the top down so the lowest free slot is the last one to win.
	always_comb begin
		free_slot.found = 1'b0;
		free_slot.idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!busy_map[i]) begin
				free_slot.found = 1'b1;
				free_slot.idx   = IDX_MAX_W'(i);
			end
		end
	end

endmodule

// ----- design/buffer_pool_allocator.sv -----
// Path: a command is taken into the command register, and the result strobe, with its
// result, comes straight from the result register that follows it.
// Throughput: one command per cycle; busy never rises and the receiver cannot stall.
// The free-slot search is one priority encoder over the bitmap in the step after
// the command register. Reset clears the bitmap, all counters, the sticky flags
// and the last failure time, and loads the congestion limit with 10.
module buffer_pool_allocator #(
	parameter int SLOT_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          operation,
	input  logic [bpa_pkg::SLOT_W-1:0]    slot,
	input  logic [bpa_pkg::TIME_W-1:0]    time_ms,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bpa_pkg::LEVEL_W-1:0]   cfg_data,
	output logic                          done,
	output logic                          granted,
	output logic [bpa_pkg::SLOT_W-1:0]    slot_index,
	output logic                          released,
	output logic [bpa_pkg::FREE_W-1:0]    free_slots,
	output logic [bpa_pkg::TOTAL_W-1:0]   alloc_total,
	output logic [bpa_pkg::TOTAL_W-1:0]   release_total,
	output logic [bpa_pkg::TOTAL_W-1:0]   fail_total,
	output logic                          congested,
	output logic [bpa_pkg::LEVEL_W-1:0]   congestion_level,
	output logic                          severe,
	output logic [bpa_pkg::TIME_W-1:0]    last_fail_ms
);
	import bpa_pkg::*;

	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int IDX_W = $clog2(SLOT_COUNT);
	localparam int HALF  = SLOT_COUNT / 2;

	// Command register
	logic              valid_s1;
	logic              op_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [TIME_W-1:0] time_s1;

	// Pool state
	logic [SLOT_COUNT-1:0] busy_map_q;
	logic [CNT_W-1:0]      busy_cnt_q;
	logic [TOTAL_W-1:0]    alloc_cnt_q;
	logic [TOTAL_W-1:0]    release_cnt_q;
	logic [TOTAL_W-1:0]    fail_cnt_q;
	logic [LEVEL_W-1:0]    level_q;
	logic                  congested_q;
	logic                  severe_q;
	logic [TIME_W-1:0]     fail_stamp_q;
	logic [LEVEL_W-1:0]    limit_q;

	// Result register
	logic              done_q;
	logic              granted_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic              released_q;

	free_slot_t        free_slot;
	logic              rel_hit;
	logic [SLOT_COUNT-1:0] rel_mask;
	logic              do_alloc;
	logic              do_fail;
	logic              do_release;
	logic [LEVEL_W-1:0] level_inc;
	logic [CNT_W-1:0]  busy_after_rel;
	logic [CNT_MAX_W-1:0] free_wide;

	bpa_free_enc #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_free_enc (
		.busy_map (busy_map_q),
		.free_slot(free_slot)
	);

	always_comb begin
		rel_mask = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			rel_mask[i] = (32'(slot_s1) == i);
		end
	end

	// A release of a free slot, or of one beyond the pool, matches nothing.
	assign rel_hit        = |(rel_mask & busy_map_q);
	assign do_alloc       = valid_s1 && (op_s1 == OP_ALLOC) && free_slot.found;
	assign do_fail        = valid_s1 && (op_s1 == OP_ALLOC) && !free_slot.found;
	assign do_release     = valid_s1 && (op_s1 == OP_RELEASE) && rel_hit;
	assign level_inc      = (level_q == LEVEL_MAX) ? level_q : level_q + 1'b1;
	assign busy_after_rel = busy_cnt_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= operation;
		slot_s1 <= slot;
		time_s1 <= time_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_map_q    <= '0;
			busy_cnt_q    <= '0;
			alloc_cnt_q   <= '0;
			release_cnt_q <= '0;
			fail_cnt_q    <= '0;
			level_q       <= '0;
			congested_q   <= 1'b0;
			severe_q      <= 1'b0;
			fail_stamp_q  <= '0;
			limit_q       <= LIMIT_RESET;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (do_alloc) begin
				busy_map_q[free_slot.idx[IDX_W-1:0]] <= 1'b1;
				busy_cnt_q  <= busy_cnt_q + 1'b1;
				alloc_cnt_q <= alloc_cnt_q + 1'b1;
			end
			if (do_fail) begin
				fail_cnt_q   <= fail_cnt_q + 1'b1;
				congested_q  <= 1'b1;
				level_q      <= level_inc;
				fail_stamp_q <= time_s1;
				if (level_inc >= limit_q) begin
					severe_q <= 1'b1;
				end
			end
			if (do_release) begin
				busy_map_q    <= busy_map_q & ~rel_mask;
				busy_cnt_q    <= busy_after_rel;
				release_cnt_q <= release_cnt_q + 1'b1;
				if (busy_after_rel < CNT_W'(HALF)) begin
					level_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		granted_q    <= do_alloc;
		slot_index_q <= do_alloc ? free_slot.idx[SLOT_W-1:0] : '0;
		released_q   <= do_release;
	end

	// The state registers change at the same edge as the strobe, so during the
	// strobe cycle they hold exactly the state after that beat.
	assign free_wide = CNT_MAX_W'(SLOT_COUNT) - CNT_MAX_W'(busy_cnt_q);

	assign busy             = 1'b0;
	assign cfg_ready        = 1'b1;
	assign done             = done_q;
	assign granted          = granted_q;
	assign slot_index       = slot_index_q;
	assign released         = released_q;
	assign free_slots       = free_wide[FREE_W-1:0];
	assign alloc_total      = alloc_cnt_q;
	assign release_total    = release_cnt_q;
	assign fail_total       = fail_cnt_q;
	assign congested        = congested_q;
	assign congestion_level = level_q;
	assign severe           = severe_q;
	assign last_fail_ms     = fail_stamp_q;

endmodule

// ----- design/bpa_checker.sv -----
// Port-level assertions for the buffer pool allocator, bound to the top level.
module bpa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        done,
	input logic                        granted,
	input logic                        released,
	input logic [bpa_pkg::FREE_W-1:0]  free_slots,
	input logic [bpa_pkg::TOTAL_W-1:0] alloc_total,
	input logic [bpa_pkg::TOTAL_W-1:0] release_total,
	input logic [bpa_pkg::TOTAL_W-1:0] fail_total,
	input logic                        congested,
	input logic                        severe
);
	import bpa_pkg::*;

	// A beat either grants or releases, never both.
	a_grant_xor_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(granted && released))
		else $error("grant and release on one beat");

	// A grant advances the allocation total by exactly one.
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(done && granted) |-> (alloc_total == $past(alloc_total) + 32'd1))
		else $error("allocation total did not step on a grant");

	// Statistics only move together with a result beat.
	a_totals_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> ($stable(alloc_total) && $stable(release_total) && $stable(fail_total)))
		else $error("totals changed without a result beat");

	// Severe congestion can only appear once congestion has been flagged.
	a_severe_needs_cong: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(severe) |-> congested)
		else $error("severe set without congestion");

	// A failed allocate or a no-op release leaves the free slot count alone.
	a_free_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted && !released) |-> (free_slots == $past(free_slots)))
		else $error("free slot count moved on a beat without grant or release");

endmodule

bind buffer_pool_allocator bpa_checker u_bpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.done         (done),
	.granted      (granted),
	.released     (released),
	.free_slots   (free_slots),
	.alloc_total  (alloc_total),
	.release_total(release_total),
	.fail_total   (fail_total),
	.congested    (congested),
	.severe       (severe)
);
